>>> rtl/interval_signal_compactor_unit_assert.svh
// Assertion macros used by the compactor controller (isc_ctrl).
// Both macros sample on the rising edge of clk; the first is disabled in reset.
`ifndef INTERVAL_SIGNAL_COMPACTOR_UNIT_ASSERT_SVH
`define INTERVAL_SIGNAL_COMPACTOR_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define ISC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ISC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ISC_ASSERT(lbl, prop, msg)
`define ISC_ASSERT_RST(lbl, prop, msg)
`endif

`endif

>>> rtl/isc_pkg.sv
`default_nettype none

package isc_pkg;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_COMPACT_ENABLE   = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_BLOCK_LENGTH = 1'b1;

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_RECORD = 1'b1;

  localparam logic        RST_COMPACT_ENABLE   = 1'b1;
  localparam logic [31:0] RST_MAX_BLOCK_LENGTH = 32'd50;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_MUL,
    S_APPLY,
    S_CHECK,
    S_DIV,
    S_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic len_load;
    logic len_inc;
    logic pass_load;
    logic gap_load;
    logic div_start;
    logic apply_open;
    logic apply_ext;
    logic close_load;
    logic out_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic keep;
    logic compact;
    logic open;
    logic gap;
    logic ovf;
    logic div_busy;
    logic div_done;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

>>> rtl/isc_ram.sv
`default_nettype none

module isc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/isc_div.sv
`default_nettype none

// Signed 32 / 33-bit divide, truncating, one quotient bit per cycle.
module isc_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] num,
  input  wire logic [32:0] den,
  output logic             busy,
  output logic             done,
  output logic [31:0]      quo
);

  localparam int STEPS = 32;
  localparam int CW    = $clog2(STEPS);

  logic [CW-1:0] cnt;
  logic [32:0]   rem;
  logic [31:0]   qr;
  logic [32:0]   dmag;
  logic          neg;
  logic          dz;

  logic [33:0] rem_sh;
  logic [33:0] diff;
  logic        qbit;
  logic [32:0] rem_next;
  logic [31:0] qr_next;

  always_comb begin
    rem_sh   = {rem, qr[31]};
    diff     = rem_sh - {1'b0, dmag};
    qbit     = !diff[33];
    rem_next = qbit ? diff[32:0] : rem_sh[32:0];
    qr_next  = {qr[30:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        qr   <= num[31] ? (~num + 32'd1) : num;
        dmag <= den[32] ? (~den + 33'd1) : den;
        neg  <= num[31] ^ den[32];
        dz   <= (den == 33'd0);
      end else if (busy) begin
        rem <= rem_next;
        qr  <= qr_next;
        cnt <= cnt + CW'(1);
        if (cnt == CW'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
          quo  <= dz ? 32'd0 : (neg ? (~qr_next + 32'd1) : qr_next);
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/isc_datapath.sv
`default_nettype none

module isc_datapath #(
  parameter int MAX_CHROMOSOMES = 256,
  localparam int AW = (MAX_CHROMOSOMES > 1) ? $clog2(MAX_CHROMOSOMES) : 1
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire isc_pkg::cmd_t                      cmd,
  output isc_pkg::stat_t                          stat,
  input  wire logic                               cfg_write_enable,
  input  wire logic [isc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [isc_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                               mode,
  input  wire logic [7:0]                         chrom,
  input  wire logic [31:0]                        start_pos,
  input  wire logic [31:0]                        end_pos,
  input  wire logic signed [31:0]                 signal,
  input  wire logic [31:0]                        chrom_size,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [7:0]                              out_chrom,
  output logic [31:0]                             out_start,
  output logic [31:0]                             out_end,
  output logic signed [31:0]                      out_level
);

  // config
  logic        compact_enable;
  logic [31:0] max_block_length;

  // captured item
  logic [7:0]  ch_q;
  logic [31:0] p1_q;
  logic [31:0] p2_q;
  logic [31:0] sig_q;
  logic        ch_ok_q;

  // block state
  logic        blk_open;
  logic [31:0] blk_start;
  logic [32:0] blk_len;
  logic [31:0] blk_sum;
  logic [31:0] last_end;
  logic [7:0]  last_chrom;

  // work registers
  logic [32:0] len_op;
  logic [31:0] prod;
  logic [7:0]  pend_chrom;
  logic [31:0] pend_start;
  logic [31:0] pend_end;
  logic [31:0] pend_level;

  logic        in_ch_ok;
  logic        ram_we;
  logic [31:0] size_rd;
  logic [32:0] diff33;
  logic        div_busy;
  logic        div_done;
  logic [31:0] div_quo;

  assign in_ch_ok = 32'(chrom) < 32'(MAX_CHROMOSOMES);
  assign ram_we   = cmd.accept && (mode == isc_pkg::MODE_LOAD) && in_ch_ok;

  isc_ram #(
    .WIDTH(32),
    .DEPTH(MAX_CHROMOSOMES)
  ) u_size_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(AW'(chrom)),
    .wdata(chrom_size),
    .re   (cmd.accept),
    .raddr(AW'(chrom)),
    .rdata(size_rd)
  );

  isc_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.div_start),
    .num  (blk_sum),
    .den  (blk_len),
    .busy (div_busy),
    .done (div_done),
    .quo  (div_quo)
  );

  assign diff33 = {1'b0, p2_q} - {1'b0, p1_q};

  always_comb begin
    stat.keep     = ch_ok_q && (p1_q < size_rd) && (p2_q < size_rd);
    stat.compact  = compact_enable;
    stat.open     = blk_open;
    stat.gap      = (last_end < p1_q) || (last_chrom != ch_q);
    stat.ovf      = !blk_len[32] && (blk_len[31:0] > max_block_length);
    stat.div_busy = div_busy;
    stat.div_done = div_done;
    stat.out_free = !out_valid || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      compact_enable   <= isc_pkg::RST_COMPACT_ENABLE;
      max_block_length <= isc_pkg::RST_MAX_BLOCK_LENGTH;
    end else if (cfg_write_enable) begin
      case (cfg_index)
        isc_pkg::REG_COMPACT_ENABLE:   compact_enable   <= cfg_data[0];
        isc_pkg::REG_MAX_BLOCK_LENGTH: max_block_length <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ch_q    <= chrom;
      p1_q    <= start_pos;
      p2_q    <= end_pos;
      sig_q   <= signal;
      ch_ok_q <= in_ch_ok;
    end
    if (cmd.len_load) begin
      len_op <= cmd.len_inc ? (diff33 + 33'd1) : diff33;
    end
    prod <= len_op[31:0] * sig_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blk_open   <= 1'b0;
      blk_start  <= '0;
      blk_len    <= '0;
      blk_sum    <= '0;
      last_end   <= '0;
      last_chrom <= '0;
    end else begin
      if (cmd.apply_open) begin
        blk_open   <= 1'b1;
        blk_start  <= p1_q;
        blk_len    <= len_op;
        blk_sum    <= prod;
        last_end   <= p2_q;
        last_chrom <= ch_q;
      end else if (cmd.apply_ext) begin
        blk_len    <= blk_len + len_op;
        blk_sum    <= blk_sum + prod;
        last_end   <= p2_q;
        last_chrom <= ch_q;
      end else if (cmd.close_load) begin
        blk_open <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pass_load) begin
      pend_chrom <= ch_q;
      pend_start <= p1_q;
      pend_end   <= p2_q;
      pend_level <= sig_q;
    end else if (cmd.gap_load) begin
      pend_chrom <= last_chrom;
      pend_start <= blk_start;
      pend_end   <= last_end;
    end else if (cmd.close_load) begin
      pend_chrom <= ch_q;
      pend_start <= blk_start;
      pend_end   <= p2_q - 32'd1;
    end
    if (div_done) begin
      pend_level <= div_quo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_chrom <= pend_chrom;
      out_start <= pend_start;
      out_end   <= pend_end;
      out_level <= pend_level;
    end
  end

endmodule

`default_nettype wire

>>> rtl/isc_ctrl.sv
`default_nettype none

module isc_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  input  wire logic           in_mode,
  output logic                in_stall,
  output isc_pkg::cmd_t       cmd,
  input  wire isc_pkg::stat_t stat
);

  isc_pkg::state_t state;
  isc_pkg::state_t state_next;
  logic            opening;
  logic            opening_next;
  logic            gap_pend;
  logic            gap_pend_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= isc_pkg::S_IDLE;
      opening  <= 1'b0;
      gap_pend <= 1'b0;
    end else begin
      state    <= state_next;
      opening  <= opening_next;
      gap_pend <= gap_pend_next;
    end
  end

  always_comb begin
    state_next    = state;
    opening_next  = opening;
    gap_pend_next = gap_pend;
    cmd           = '0;
    in_stall      = (state != isc_pkg::S_IDLE);
    case (state)
      isc_pkg::S_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid && (in_mode == isc_pkg::MODE_RECORD)) begin
          state_next = isc_pkg::S_EVAL;
        end
      end
      isc_pkg::S_EVAL: begin
        if (!stat.keep) begin
          state_next = isc_pkg::S_IDLE;
        end else if (!stat.compact) begin
          cmd.pass_load = 1'b1;
          state_next    = isc_pkg::S_OUT;
        end else if (!stat.open) begin
          cmd.len_load  = 1'b1;
          cmd.len_inc   = 1'b1;
          opening_next  = 1'b1;
          gap_pend_next = 1'b0;
          state_next    = isc_pkg::S_MUL;
        end else if (stat.gap) begin
          // old block divides while the new one opens
          cmd.gap_load  = 1'b1;
          cmd.div_start = 1'b1;
          cmd.len_load  = 1'b1;
          cmd.len_inc   = 1'b1;
          opening_next  = 1'b1;
          gap_pend_next = 1'b1;
          state_next    = isc_pkg::S_MUL;
        end else begin
          cmd.len_load  = 1'b1;
          opening_next  = 1'b0;
          gap_pend_next = 1'b0;
          state_next    = isc_pkg::S_MUL;
        end
      end
      isc_pkg::S_MUL: begin
        state_next = isc_pkg::S_APPLY;
      end
      isc_pkg::S_APPLY: begin
        if (opening) begin
          cmd.apply_open = 1'b1;
          state_next     = gap_pend ? isc_pkg::S_DIV : isc_pkg::S_IDLE;
        end else begin
          cmd.apply_ext = 1'b1;
          state_next    = isc_pkg::S_CHECK;
        end
      end
      isc_pkg::S_CHECK: begin
        if (stat.ovf) begin
          cmd.close_load = 1'b1;
          cmd.div_start  = 1'b1;
          state_next     = isc_pkg::S_DIV;
        end else begin
          state_next = isc_pkg::S_IDLE;
        end
      end
      isc_pkg::S_DIV: begin
        if (stat.div_done) begin
          state_next = isc_pkg::S_OUT;
        end
      end
      isc_pkg::S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = isc_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = isc_pkg::S_IDLE;
      end
    endcase
  end

`include "interval_signal_compactor_unit_assert.svh"

  `ISC_ASSERT(a_div_start_idle, cmd.div_start |-> !stat.div_busy, "divide started while busy")
  `ISC_ASSERT(a_out_no_overwrite, cmd.out_load |-> stat.out_free, "pending result overwritten")
  `ISC_ASSERT(a_div_done_in_wait, stat.div_done |-> (state == isc_pkg::S_DIV), "quotient not awaited")

endmodule

`default_nettype wire

>>> rtl/interval_signal_compactor_unit.sv
`default_nettype none

// Channel   Direction  Handshake             Payload
// input     in         in_valid / in_stall   mode chrom start_pos end_pos signal chrom_size
// output    out        out_valid / out_stall out_chrom out_start out_end out_level
// config    in         cfg_write_enable      cfg_index cfg_data
//
// Per transfer: a size load is taken in S_IDLE; a record goes to S_EVAL, which drops it,
// passes it through S_OUT, or runs S_MUL and S_APPLY to open a block or extend one (then S_CHECK).
// A close adds the divider (one quotient bit per cycle) in S_DIV, then S_OUT: on a gap or
// chromosome change, while the new block opens, or when S_CHECK finds the length limit crossed.
// Reset (rst, synchronous) clears control and block state; size entries are undefined
// until loaded. A result waiting on out_stall holds the controller only when the
// output register is still full.
module interval_signal_compactor_unit #(
  parameter int MAX_CHROMOSOMES = 256
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // configuration
  input  wire logic                            cfg_write_enable,
  input  wire logic [isc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [isc_pkg::CFG_DATA_W-1:0]  cfg_data,
  // input channel
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            mode,
  input  wire logic [7:0]                      chrom,
  input  wire logic [31:0]                     start_pos,
  input  wire logic [31:0]                     end_pos,
  input  wire logic signed [31:0]              signal,
  input  wire logic [31:0]                     chrom_size,
  // output channel
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [7:0]                           out_chrom,
  output logic [31:0]                          out_start,
  output logic [31:0]                          out_end,
  output logic signed [31:0]                   out_level
);

  isc_pkg::cmd_t  cmd;
  isc_pkg::stat_t stat;

  // sequencing: accept, lookup, multiply, accumulate, close, divide, hand-off
  isc_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_mode (mode),
    .in_stall(in_stall),
    .cmd     (cmd),
    .stat    (stat)
  );

  // size table, block accumulators, divider and output register
  isc_datapath #(
    .MAX_CHROMOSOMES(MAX_CHROMOSOMES)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_write_enable(cfg_write_enable),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mode            (mode),
    .chrom           (chrom),
    .start_pos       (start_pos),
    .end_pos         (end_pos),
    .signal          (signal),
    .chrom_size      (chrom_size),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_chrom       (out_chrom),
    .out_start       (out_start),
    .out_end         (out_end),
    .out_level       (out_level)
  );

endmodule

`default_nettype wire
